// ----- sv/trs_pkg.sv -----
// shared types and constants for the transform compose pipeline
package trs_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int SCALE_W = 24;
    localparam int ENT_W   = 24;
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int ROT_W   = 35;
    localparam int MUL_W   = ROT_W + SCALE_W;
    localparam int FRAC_SH = 28;
    localparam int SHR_W   = MUL_W - FRAC_SH;

    // fixed-point constants
    localparam logic signed [ROT_W-1:0] ROT_ONE    = ROT_W'(64'sd1 <<< FRAC_SH);
    localparam logic signed [MUL_W-1:0] ROUND_BIAS = MUL_W'(64'sd1 <<< (FRAC_SH - 1));
    localparam logic signed [SHR_W-1:0] Q716_MAX   = SHR_W'(64'sd8388607);
    localparam logic signed [SHR_W-1:0] Q716_MIN   = SHR_W'(-64'sd8388608);

    // one incoming transform
    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [QUAT_W-1:0]  quat_x;
        logic signed [QUAT_W-1:0]  quat_y;
        logic signed [QUAT_W-1:0]  quat_z;
        logic signed [QUAT_W-1:0]  quat_w;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic signed [SCALE_W-1:0] scale_z;
    } t_trs_req;

    // one outgoing matrix
    typedef struct packed {
        logic signed [ENT_W-1:0] m00;
        logic signed [ENT_W-1:0] m01;
        logic signed [ENT_W-1:0] m02;
        logic signed [ENT_W-1:0] m10;
        logic signed [ENT_W-1:0] m11;
        logic signed [ENT_W-1:0] m12;
        logic signed [ENT_W-1:0] m20;
        logic signed [ENT_W-1:0] m21;
        logic signed [ENT_W-1:0] m22;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] tz;
    } t_trs_res;

    // position and scale carried down the pipe
    typedef struct packed {
        logic [2:0][POS_W-1:0]   pos;
        logic [2:0][SCALE_W-1:0] scale;
    } t_trs_side;

    // quaternion products, lsb 2^-28
    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] wz;
        t_trs_side                side;
    } t_trs_prod;

    // rotation entries, row major, 1.0 = 2^28
    typedef struct packed {
        logic [8:0][ROT_W-1:0] rot;
        t_trs_side             side;
    } t_trs_rot;

endpackage

// ----- sv/trs_quat_products.sv -----
// first stage: the nine quaternion products
module trs_quat_products (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  trs_pkg::t_trs_req i_req,
    output logic              o_valid,
    output trs_pkg::t_trs_prod o_prod
);
    import trs_pkg::*;

    logic      r_valid;
    t_trs_prod r_prod;
    t_trs_prod n_prod;

    // products of the components, each exact in 32 bits
    always_comb begin
        n_prod.xx = PROD_W'(i_req.quat_x) * PROD_W'(i_req.quat_x);
        n_prod.yy = PROD_W'(i_req.quat_y) * PROD_W'(i_req.quat_y);
        n_prod.zz = PROD_W'(i_req.quat_z) * PROD_W'(i_req.quat_z);
        n_prod.xy = PROD_W'(i_req.quat_x) * PROD_W'(i_req.quat_y);
        n_prod.xz = PROD_W'(i_req.quat_x) * PROD_W'(i_req.quat_z);
        n_prod.yz = PROD_W'(i_req.quat_y) * PROD_W'(i_req.quat_z);
        n_prod.wx = PROD_W'(i_req.quat_w) * PROD_W'(i_req.quat_x);
        n_prod.wy = PROD_W'(i_req.quat_w) * PROD_W'(i_req.quat_y);
        n_prod.wz = PROD_W'(i_req.quat_w) * PROD_W'(i_req.quat_z);
        n_prod.side.pos[0]   = i_req.pos_x;
        n_prod.side.pos[1]   = i_req.pos_y;
        n_prod.side.pos[2]   = i_req.pos_z;
        n_prod.side.scale[0] = i_req.scale_x;
        n_prod.side.scale[1] = i_req.scale_y;
        n_prod.side.scale[2] = i_req.scale_z;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

// ----- sv/trs_rot_build.sv -----
// second stage: rotation matrix entries from the products
module trs_rot_build (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  trs_pkg::t_trs_prod i_prod,
    output logic               o_valid,
    output trs_pkg::t_trs_rot  o_rot
);
    import trs_pkg::*;

    logic     r_valid;
    t_trs_rot r_rot;
    t_trs_rot n_rot;

    // widened products
    logic signed [ROT_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

    assign xx = ROT_W'(i_prod.xx);
    assign yy = ROT_W'(i_prod.yy);
    assign zz = ROT_W'(i_prod.zz);
    assign xy = ROT_W'(i_prod.xy);
    assign xz = ROT_W'(i_prod.xz);
    assign yz = ROT_W'(i_prod.yz);
    assign wx = ROT_W'(i_prod.wx);
    assign wy = ROT_W'(i_prod.wy);
    assign wz = ROT_W'(i_prod.wz);

    // standard quaternion to rotation formula, exact
    always_comb begin
        n_rot.rot[0] = ROT_ONE - ((yy + zz) <<< 1);
        n_rot.rot[1] = (xy - wz) <<< 1;
        n_rot.rot[2] = (xz + wy) <<< 1;
        n_rot.rot[3] = (xy + wz) <<< 1;
        n_rot.rot[4] = ROT_ONE - ((xx + zz) <<< 1);
        n_rot.rot[5] = (yz - wx) <<< 1;
        n_rot.rot[6] = (xz - wy) <<< 1;
        n_rot.rot[7] = (yz + wx) <<< 1;
        n_rot.rot[8] = ROT_ONE - ((xx + yy) <<< 1);
        n_rot.side   = i_prod.side;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;

endmodule

// ----- sv/trs_scale_round.sv -----
// third and fourth stages: column scale multiply, then round and saturate
module trs_scale_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  trs_pkg::t_trs_rot i_rot,
    output logic              o_valid,
    output trs_pkg::t_trs_res o_res
);
    import trs_pkg::*;

    logic                     r_mul_valid;
    logic signed [MUL_W-1:0]  r_mul [9];
    logic signed [MUL_W-1:0]  n_mul [9];
    logic [2:0][POS_W-1:0]    r_pos;

    logic                     r_res_valid;
    t_trs_res                 r_res;
    logic signed [ENT_W-1:0]  n_ent [9];

    // each entry times the scale of its column, exact
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_mul[i] = MUL_W'($signed(i_rot.rot[i])) *
                       MUL_W'($signed(i_rot.side.scale[i % 3]));
        end
    end

    // round half up to lsb 2^-16 and clamp to the 24-bit range
    always_comb begin
        logic signed [MUL_W-1:0] biased;
        logic signed [SHR_W-1:0] shr;
        for (int i = 0; i < 9; i++) begin
            biased = r_mul[i] + ROUND_BIAS;
            shr    = biased[MUL_W-1:FRAC_SH];
            priority if (shr > Q716_MAX) begin
                n_ent[i] = ENT_W'(Q716_MAX);
            end else if (shr < Q716_MIN) begin
                n_ent[i] = ENT_W'(Q716_MIN);
            end else begin
                n_ent[i] = shr[ENT_W-1:0];
            end
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_mul_valid <= i_valid;
            r_res_valid <= r_mul_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_mul     <= n_mul;
        r_pos     <= i_rot.side.pos;
        r_res.m00 <= n_ent[0];
        r_res.m01 <= n_ent[1];
        r_res.m02 <= n_ent[2];
        r_res.m10 <= n_ent[3];
        r_res.m11 <= n_ent[4];
        r_res.m12 <= n_ent[5];
        r_res.m20 <= n_ent[6];
        r_res.m21 <= n_ent[7];
        r_res.m22 <= n_ent[8];
        r_res.tx  <= r_pos[0];
        r_res.ty  <= r_pos[1];
        r_res.tz  <= r_pos[2];
    end

    assign o_valid = r_res_valid;
    assign o_res   = r_res;

endmodule

// ----- sv/trs_transform_compose_unit.sv -----
// top level: position, quaternion and scale to a 3x4 affine matrix
//
// A request is taken at each rising edge where start is high and busy is
// low. busy is low outside reset, so one request may be issued every cycle.
// Each request carries position (Q15.16), quaternion (Q1.14, not
// normalised) and per-axis scale (Q7.16). The result is the upper three
// rows of T*R*S: nine Q7.16 rotation-scale entries, rounded half up and
// saturated, plus the position passed through as the translation column.
// Each result appears on o_res with o_strobe high for one cycle, once
// its request has passed the register stages below, and is taken by
// the receiver at the edge that ends that cycle.
// Throughput is one result per cycle, set by the four register stages
// (quaternion products, rotation entries, column scale multiply,
// rounding) that each hold one request.
// The receiver takes every result in the cycle it is shown and cannot
// hold results off. Synchronous reset clears the valid bits and holds busy
// high, so no strobe is raised for requests in flight at reset.
module trs_transform_compose_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  trs_pkg::t_trs_req i_req,
    output logic              o_strobe,
    output trs_pkg::t_trs_res o_res
);
    import trs_pkg::*;

    logic      prod_valid;
    t_trs_prod prod;
    logic      rot_valid;
    t_trs_rot  rot;
    logic      accept;

    // the pipeline never stalls; requests are refused only in reset
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // quaternion products
    trs_quat_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_req   (i_req),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    // rotation entries
    trs_rot_build u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_prod  (prod),
        .o_valid (rot_valid),
        .o_rot   (rot)
    );

    // scale, round and saturate
    trs_scale_round u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rot_valid),
        .i_rot   (rot),
        .o_valid (o_strobe),
        .o_res   (o_res)
    );

endmodule

// ----- tb/sv/trs_transform_compose_unit_tb.sv -----
// self-checking testbench for the quaternion transform to affine matrix unit
module trs_transform_compose_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trs_pkg::*;

    localparam int     N_RANDOM    = 1400;
    localparam int     CYCLE_LIMIT = 100000;
    localparam int     DRAIN_WAIT  = 12;
    localparam longint ROT_UNIT    = longint'(1) <<< FRAC_SH;
    localparam longint RND_HALF    = longint'(1) <<< (FRAC_SH - 1);
    localparam longint ENT_MAX     = (longint'(1) <<< (ENT_W - 1)) - 1;
    localparam longint ENT_MIN     = -(longint'(1) <<< (ENT_W - 1));

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_trs_req i_req   = '0;
    logic     o_strobe;
    t_trs_res o_res;

    t_trs_req pending_transforms[$];
    t_trs_res expected_matrices[$];

    int n_total   = 0;
    int n_directed = 0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_errors  = 0;
    int n_cycles  = 0;
    int gap_left  = 0;
    bit burst     = 1'b0;

    trs_transform_compose_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // rotation entry times column scale, rounded half up and clamped to Q7.16
    function automatic logic signed [ENT_W-1:0] scale_and_round(longint rot, longint scale);
        longint acc;
        acc = (rot * scale + RND_HALF) >>> FRAC_SH;
        if (acc > ENT_MAX) begin
            acc = ENT_MAX;
        end else if (acc < ENT_MIN) begin
            acc = ENT_MIN;
        end
        return acc[ENT_W-1:0];
    endfunction

    // expected matrix for one transform
    function automatic t_trs_res compose_matrix(t_trs_req r);
        longint   qx, qy, qz, qw, sx, sy, sz;
        longint   xx, yy, zz, xy, xz, yz, wx, wy, wz;
        t_trs_res m;
        qx = longint'($signed(r.quat_x));
        qy = longint'($signed(r.quat_y));
        qz = longint'($signed(r.quat_z));
        qw = longint'($signed(r.quat_w));
        sx = longint'($signed(r.scale_x));
        sy = longint'($signed(r.scale_y));
        sz = longint'($signed(r.scale_z));
        xx = qx * qx; yy = qy * qy; zz = qz * qz;
        xy = qx * qy; xz = qx * qz; yz = qy * qz;
        wx = qw * qx; wy = qw * qy; wz = qw * qz;
        m.m00 = scale_and_round(ROT_UNIT - 2 * (yy + zz), sx);
        m.m01 = scale_and_round(2 * (xy - wz), sy);
        m.m02 = scale_and_round(2 * (xz + wy), sz);
        m.m10 = scale_and_round(2 * (xy + wz), sx);
        m.m11 = scale_and_round(ROT_UNIT - 2 * (xx + zz), sy);
        m.m12 = scale_and_round(2 * (yz - wx), sz);
        m.m20 = scale_and_round(2 * (xz - wy), sx);
        m.m21 = scale_and_round(2 * (yz + wx), sy);
        m.m22 = scale_and_round(ROT_UNIT - 2 * (xx + yy), sz);
        m.tx  = r.pos_x;
        m.ty  = r.pos_y;
        m.tz  = r.pos_z;
        return m;
    endfunction

    // one field of a matrix
    function automatic void check_entry(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d got %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // queue one transform for the driver
    task automatic add_transform(input int px, py, pz, qx, qy, qz, qw, sx, sy, sz);
        t_trs_req r;
        r.pos_x   = POS_W'(px);
        r.pos_y   = POS_W'(py);
        r.pos_z   = POS_W'(pz);
        r.quat_x  = QUAT_W'(qx);
        r.quat_y  = QUAT_W'(qy);
        r.quat_z  = QUAT_W'(qz);
        r.quat_w  = QUAT_W'(qw);
        r.scale_x = SCALE_W'(sx);
        r.scale_y = SCALE_W'(sy);
        r.scale_z = SCALE_W'(sz);
        pending_transforms.insert(pending_transforms.size(), r);
    endtask

    // field value biased towards the ends of its range
    function automatic int edgy_bits(int unsigned w);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = (32'h1 << (w - 1)) - 32'h1;
            1:       v = ~((32'h1 << (w - 1)) - 32'h1);
            2:       v = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            3:       v = $urandom_range(0, 1) ? 32'h1 : 32'h0001_0000;
            default: v = $urandom;
        endcase
        return int'(v);
    endfunction

    // request driver: start held until taken, random gaps between requests
    always @(posedge i_clk) begin : drv
        bit taken;
        taken = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (taken) begin
                expected_matrices.insert(expected_matrices.size(), compose_matrix(i_req));
                n_sent++;
            end
            if (taken || !start) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_transforms.size() != 0) begin
                    i_req <= pending_transforms.pop_front();
                    start <= 1'b1;
                    if ($urandom_range(0, 39) == 0) begin
                        burst = !burst;
                    end
                    gap_left = burst ? 0 : $urandom_range(0, 6);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor: every strobe must match the oldest expected matrix
    always @(posedge i_clk) begin : mon
        t_trs_res want;
        if (i_rst_n && o_strobe) begin
            if (expected_matrices.size() == 0) begin
                $display("%0t ns: unexpected matrix, expected none got %h", $time, o_res);
                n_errors++;
            end else begin
                want = expected_matrices.pop_front();
                check_entry("m00", longint'(want.m00), longint'(o_res.m00));
                check_entry("m01", longint'(want.m01), longint'(o_res.m01));
                check_entry("m02", longint'(want.m02), longint'(o_res.m02));
                check_entry("m10", longint'(want.m10), longint'(o_res.m10));
                check_entry("m11", longint'(want.m11), longint'(o_res.m11));
                check_entry("m12", longint'(want.m12), longint'(o_res.m12));
                check_entry("m20", longint'(want.m20), longint'(o_res.m20));
                check_entry("m21", longint'(want.m21), longint'(o_res.m21));
                check_entry("m22", longint'(want.m22), longint'(o_res.m22));
                check_entry("tx", longint'(want.tx), longint'(o_res.tx));
                check_entry("ty", longint'(want.ty), longint'(o_res.ty));
                check_entry("tz", longint'(want.tz), longint'(o_res.tz));
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("%0t ns: run timed out with %0d matrices outstanding", $time,
                     n_total - n_checked);
            $display("[trs_transform_compose_unit] ERROR");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        real qa[4];
        real norm;
        int  qv[4];
        int  sc[3];
        int  k;
        int  kind;

        // identity and zero quaternion: pure scale
        add_transform(0, 0, 0, 0, 0, 0, 16384, 65536, 65536, 65536);
        add_transform(65536, -65536, 1, 0, 0, 0, 0, 65536, -131072, 8388607);
        add_transform(-1, 7, 0, 0, 0, 0, 0, -8388608, 0, 1);
        // quarter turns about each axis, position at its extremes
        add_transform(65536, -65536, 32'h7FFF_FFFF, 11585, 0, 0, 11585, 65536, 65536, 65536);
        add_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      0, 11585, 0, 11585, 131072, 65536, -65536);
        add_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      0, 0, 11585, 11585, 65536, 196608, 65536);
        // half turns
        add_transform(1, 2, 3, 16384, 0, 0, 0, 65536, 65536, 65536);
        add_transform(-1, -2, -3, 0, 16384, 0, 0, 65536, 65536, 65536);
        add_transform(0, 0, 0, 0, 0, 16384, 0, 65536, 65536, 65536);
        // exact halves: rounding goes towards plus infinity
        add_transform(0, 0, 0, 8192, 8192, 0, 0, 1, 1, 1);
        add_transform(0, 0, 0, 8192, 8192, 0, 0, -1, -1, -1);
        // quaternion components at their limits, clamped entries
        add_transform(0, 0, 0, 32767, 32767, 32767, 32767, 8388607, 8388607, 8388607);
        add_transform(0, 0, 0, -32768, -32768, -32768, -32768, 8388607, 8388607, 8388607);
        add_transform(0, 0, 0, -32768, -32768, -32768, -32768, -8388608, -8388608, -8388608);
        add_transform(5, 6, 7, -32768, 32767, -32768, 32767, 8388607, -8388608, 65536);
        add_transform(0, 0, 0, 0, 0, 0, 32767, 8388607, -8388608, 8388607);
        // negated identity with mirroring scale
        add_transform(100, 200, 300, 0, 0, 0, -16384, -65536, -65536, -65536);
        add_transform(-1, -1, -1, 1, -1, 1, -1, -1, 1, 0);
        // third of a turn about the diagonal, and a quaternion of length two
        add_transform(32'h8000_0000, 32'h7FFF_FFFF, 0, 8192, 8192, 8192, 8192,
                      196608, 32768, 1);
        add_transform(0, 0, 0, 16384, 16384, 16384, 16384, 65536, 65536, 65536);
        n_directed = pending_transforms.size();

        // random transforms: mostly proper rotations, some raw bit patterns
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                norm = 0.0;
                for (k = 0; k < 4; k++) begin
                    qa[k] = 2.0 * real'($urandom) / 4294967295.0 - 1.0;
                    norm += qa[k] * qa[k];
                end
                norm = $sqrt(norm);
                if (norm < 0.01) begin
                    qa[0] = 0.0; qa[1] = 0.0; qa[2] = 0.0; qa[3] = 1.0;
                    norm = 1.0;
                end
                for (k = 0; k < 4; k++) begin
                    qv[k] = $rtoi(qa[k] / norm * 16384.0);
                end
            end else begin
                for (k = 0; k < 4; k++) begin
                    qv[k] = edgy_bits(QUAT_W);
                end
            end
            for (k = 0; k < 3; k++) begin
                if (kind < 6) begin
                    // scale within +/-4.0
                    sc[k] = int'($urandom_range(0, 524288)) - 262144;
                end else begin
                    sc[k] = edgy_bits(SCALE_W);
                end
            end
            add_transform(edgy_bits(POS_W), edgy_bits(POS_W), edgy_bits(POS_W),
                          qv[0], qv[1], qv[2], qv[3], sc[0], sc[1], sc[2]);
        end
        n_total = pending_transforms.size();

        // synchronous reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every matrix, then watch for strays
        wait (n_checked == n_total);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_matrices.size() != 0) begin
            $display("%0t ns: %0d matrices never arrived, expected 0 left got %0d", $time,
                     expected_matrices.size(), expected_matrices.size());
            n_errors++;
        end

        $display("%0d transforms sent (%0d directed corner cases, %0d random)",
                 n_sent, n_directed, n_total - n_directed);
        $display("%0d matrices compared field by field, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("[trs_transform_compose_unit] OK");
        end else begin
            $display("[trs_transform_compose_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/trs_pkg.sv
sv/trs_quat_products.sv
sv/trs_rot_build.sv
sv/trs_scale_round.sv
sv/trs_transform_compose_unit.sv
tb/sv/trs_transform_compose_unit_tb.sv
